[hw/rtl/hsv2rgb_pkg.sv]
// ----------------------------------------------------------------------------
// HSV to RGB package
// Shared constants and the word types passed between pipeline stages.
// ----------------------------------------------------------------------------
package hsv2rgb_pkg;

  localparam int unsigned HueWidth   = 16;
  localparam int unsigned FixWidth   = 10;
  localparam int unsigned ChanWidth  = 8;
  localparam int unsigned BiasWidth  = HueWidth + 1;
  localparam int unsigned QuotWidth  = 11;
  localparam int unsigned RemWidth   = 6;
  localparam int unsigned UnitWidth  = 9;
  localparam int unsigned SecWidth   = 3;
  localparam int unsigned TermWidth  = 14;
  localparam int unsigned NumWidth   = 22;
  localparam int unsigned ScaleWidth = 14;

  localparam int unsigned InDataWidth  = 40;
  localparam int unsigned OutDataWidth = 24;

  // 92 full turns, enough to lift any 16-bit hue above zero.
  localparam logic [BiasWidth:0]   HueBias   = 18'd33120;
  localparam logic [BiasWidth-1:0] Div60Mul  = 17'd69906;
  localparam int unsigned          Div60Shift = 22;
  localparam logic [QuotWidth-1:0] Div6Mul   = 11'd1366;
  localparam int unsigned          Div6Shift = 13;
  localparam logic [14:0]          Chan60Mul = 15'd17477;
  localparam int unsigned          Chan60Shift = 20;

  localparam logic [UnitWidth-1:0] FixOne    = 9'd256;
  localparam logic [RemWidth-1:0]  Sector    = 6'd60;
  localparam logic [TermWidth-1:0] FullTerm  = 14'd15360;

  localparam logic [SecWidth-1:0] SecRedYel = 3'd0;
  localparam logic [SecWidth-1:0] SecYelGrn = 3'd1;
  localparam logic [SecWidth-1:0] SecGrnCyn = 3'd2;
  localparam logic [SecWidth-1:0] SecCynBlu = 3'd3;
  localparam logic [SecWidth-1:0] SecBluMag = 3'd4;
  localparam logic [SecWidth-1:0] SecMagRed = 3'd5;

  typedef struct packed {
    logic signed [HueWidth-1:0] hue_deg;
    logic signed [FixWidth-1:0] saturation;
    logic signed [FixWidth-1:0] brightness;
  } pixel_t;

  typedef struct packed {
    logic [QuotWidth-1:0] quot;
    logic [RemWidth-1:0]  rem;
    logic [UnitWidth-1:0] sat;
    logic [UnitWidth-1:0] val;
  } split_t;

  typedef struct packed {
    logic [SecWidth-1:0]  sector;
    logic [UnitWidth-1:0] val;
    logic [TermWidth-1:0] term_p;
    logic [TermWidth-1:0] term_q;
    logic [TermWidth-1:0] term_t;
  } terms_t;

  typedef struct packed {
    logic [SecWidth-1:0] sector;
    logic [NumWidth-1:0] num_v;
    logic [NumWidth-1:0] num_p;
    logic [NumWidth-1:0] num_q;
    logic [NumWidth-1:0] num_t;
  } nums_t;

  typedef struct packed {
    logic [ChanWidth-1:0] blue;
    logic [ChanWidth-1:0] green;
    logic [ChanWidth-1:0] red;
  } rgb_t;

  function automatic logic [UnitWidth-1:0] clamp_unit(logic signed [FixWidth-1:0] x);
    logic [UnitWidth-1:0] res;
    res = x[UnitWidth-1:0];
    if (x[FixWidth-1]) begin
      res = '0;
    end else if (x > $signed({1'b0, FixOne})) begin
      res = FixOne;
    end
    return res;
  endfunction

endpackage

[hw/rtl/hsv_to_rgb_converter_unit.sv]
// ----------------------------------------------------------------------------
// HSV to RGB converter
// Channel   Direction  Word contents
// s_axis    in         hue_deg[15:0], saturation[25:16], brightness[35:26]
// m_axis    out        red[7:0], green[15:8], blue[23:16]
//
// A pixel word passes through the four register stages in order: hue split,
// sector and terms, value products, channel scaling; the last is the output
// register. One word is accepted per cycle unless a stall reaches the input.
// Reset clears only the stage valid bits. A stall at the output holds the full
// stages from the output back to the first empty one; stages behind a gap still
// advance and the input still takes new words while any stage is empty.
// ----------------------------------------------------------------------------
module hsv_to_rgb_converter_unit (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 s_axis_tvalid_i,
  output logic                                 s_axis_tready_o,
  // hue_deg, saturation, brightness from bit 0 up; bits 39:36 zero.
  input  logic [hsv2rgb_pkg::InDataWidth-1:0]  s_axis_tdata_i,
  output logic                                 m_axis_tvalid_o,
  input  logic                                 m_axis_tready_i,
  // red, green, blue from bit 0 up.
  output logic [hsv2rgb_pkg::OutDataWidth-1:0] m_axis_tdata_o
);

  hsv2rgb_pkg::pixel_t  pix;
  hsv2rgb_pkg::split_t  split_w;
  hsv2rgb_pkg::terms_t  terms_w;
  hsv2rgb_pkg::nums_t   nums_w;
  hsv2rgb_pkg::rgb_t    rgb_w;
  logic                 split_valid, split_ready;
  logic                 terms_valid, terms_ready;
  logic                 nums_valid, nums_ready;

  assign pix.hue_deg    = s_axis_tdata_i[15:0];
  assign pix.saturation = s_axis_tdata_i[25:16];
  assign pix.brightness = s_axis_tdata_i[35:26];

  hsv2rgb_wrap u_wrap (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid_i),
    .ready_o (s_axis_tready_o),
    .data_i  (pix),
    .valid_o (split_valid),
    .ready_i (split_ready),
    .data_o  (split_w)
  );

  hsv2rgb_terms u_terms (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (split_valid),
    .ready_o (split_ready),
    .data_i  (split_w),
    .valid_o (terms_valid),
    .ready_i (terms_ready),
    .data_o  (terms_w)
  );

  hsv2rgb_mult u_mult (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (terms_valid),
    .ready_o (terms_ready),
    .data_i  (terms_w),
    .valid_o (nums_valid),
    .ready_i (nums_ready),
    .data_o  (nums_w)
  );

  hsv2rgb_chan u_chan (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (nums_valid),
    .ready_o (nums_ready),
    .data_i  (nums_w),
    .valid_o (m_axis_tvalid_o),
    .ready_i (m_axis_tready_i),
    .data_o  (rgb_w)
  );

  assign m_axis_tdata_o = {rgb_w.blue, rgb_w.green, rgb_w.red};

endmodule

[hw/rtl/hsv2rgb_wrap.sv]
// ----------------------------------------------------------------------------
// HSV to RGB hue split stage
// Splits the biased hue into a count of 60-degree steps and the remainder,
// and clamps saturation and value to the unit range.
// ----------------------------------------------------------------------------
module hsv2rgb_wrap (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  valid_i,
  output logic                  ready_o,
  input  hsv2rgb_pkg::pixel_t   data_i,
  output logic                  valid_o,
  input  logic                  ready_i,
  output hsv2rgb_pkg::split_t   data_o
);

  logic                                    valid_q;
  hsv2rgb_pkg::split_t                     data_d, data_q;
  logic [hsv2rgb_pkg::BiasWidth:0]         hue_sum;
  logic [hsv2rgb_pkg::BiasWidth-1:0]       hue_pos;
  logic [2*hsv2rgb_pkg::BiasWidth-1:0]     quot_prod;
  logic [hsv2rgb_pkg::BiasWidth-1:0]       quot_ext;
  logic [hsv2rgb_pkg::BiasWidth-1:0]       rem_full;

  assign ready_o = !valid_q || ready_i;

  always_comb begin
    hue_sum   = {{2{data_i.hue_deg[hsv2rgb_pkg::HueWidth-1]}}, data_i.hue_deg}
                + hsv2rgb_pkg::HueBias;
    hue_pos   = hue_sum[hsv2rgb_pkg::BiasWidth-1:0];
    quot_prod = hue_pos * hsv2rgb_pkg::Div60Mul;
    data_d.quot = quot_prod[hsv2rgb_pkg::Div60Shift +: hsv2rgb_pkg::QuotWidth];
    quot_ext  = {{(hsv2rgb_pkg::BiasWidth-hsv2rgb_pkg::QuotWidth){1'b0}}, data_d.quot};
    rem_full  = hue_pos - hsv2rgb_pkg::BiasWidth'(quot_ext * hsv2rgb_pkg::Sector);
    data_d.rem = rem_full[hsv2rgb_pkg::RemWidth-1:0];
    data_d.sat = hsv2rgb_pkg::clamp_unit(data_i.saturation);
    data_d.val = hsv2rgb_pkg::clamp_unit(data_i.brightness);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

[hw/rtl/hsv2rgb_terms.sv]
// ----------------------------------------------------------------------------
// HSV to RGB term stage
// Reduces the step count to a sector 0..5 and forms the p, q and t factors
// over a common scale of 256*60.
// ----------------------------------------------------------------------------
module hsv2rgb_terms (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  valid_i,
  output logic                  ready_o,
  input  hsv2rgb_pkg::split_t   data_i,
  output logic                  valid_o,
  input  logic                  ready_i,
  output hsv2rgb_pkg::terms_t   data_o
);

  logic                                    valid_q;
  hsv2rgb_pkg::terms_t                     data_d, data_q;
  logic [2*hsv2rgb_pkg::QuotWidth-1:0]     div6_prod;
  logic [hsv2rgb_pkg::QuotWidth-1:0]       div6_quot;
  logic [hsv2rgb_pkg::QuotWidth-1:0]       sec_full;
  logic [hsv2rgb_pkg::RemWidth-1:0]        rem_inv;
  logic [hsv2rgb_pkg::TermWidth:0]         sat_rem;
  logic [hsv2rgb_pkg::TermWidth:0]         sat_inv;
  logic [hsv2rgb_pkg::TermWidth:0]         p_full;
  logic [hsv2rgb_pkg::UnitWidth-1:0]       sat_cmp;

  assign ready_o = !valid_q || ready_i;

  always_comb begin
    div6_prod = data_i.quot * hsv2rgb_pkg::Div6Mul;
    div6_quot = div6_prod[hsv2rgb_pkg::Div6Shift +: hsv2rgb_pkg::QuotWidth];
    sec_full  = data_i.quot - hsv2rgb_pkg::QuotWidth'(div6_quot * 4'd6);
    rem_inv   = hsv2rgb_pkg::Sector - data_i.rem;
    sat_rem   = data_i.sat * data_i.rem;
    sat_inv   = data_i.sat * rem_inv;
    sat_cmp   = hsv2rgb_pkg::FixOne - data_i.sat;
    p_full    = sat_cmp * hsv2rgb_pkg::Sector;
    data_d.sector = sec_full[hsv2rgb_pkg::SecWidth-1:0];
    data_d.val    = data_i.val;
    data_d.term_p = p_full[hsv2rgb_pkg::TermWidth-1:0];
    data_d.term_q = hsv2rgb_pkg::FullTerm - sat_rem[hsv2rgb_pkg::TermWidth-1:0];
    data_d.term_t = hsv2rgb_pkg::FullTerm - sat_inv[hsv2rgb_pkg::TermWidth-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

[hw/rtl/hsv2rgb_mult.sv]
// ----------------------------------------------------------------------------
// HSV to RGB product stage
// Scales the value, p, q and t factors by the clamped value.
// ----------------------------------------------------------------------------
module hsv2rgb_mult (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  valid_i,
  output logic                  ready_o,
  input  hsv2rgb_pkg::terms_t   data_i,
  output logic                  valid_o,
  input  logic                  ready_i,
  output hsv2rgb_pkg::nums_t    data_o
);

  localparam int unsigned ProdWidth = hsv2rgb_pkg::UnitWidth + hsv2rgb_pkg::TermWidth;

  logic                    valid_q;
  hsv2rgb_pkg::nums_t      data_d, data_q;
  logic [ProdWidth-1:0]    prod_v, prod_p, prod_q, prod_t;

  assign ready_o = !valid_q || ready_i;

  always_comb begin
    prod_v = data_i.val * hsv2rgb_pkg::FullTerm;
    prod_p = data_i.val * data_i.term_p;
    prod_q = data_i.val * data_i.term_q;
    prod_t = data_i.val * data_i.term_t;
    data_d.sector = data_i.sector;
    data_d.num_v  = prod_v[hsv2rgb_pkg::NumWidth-1:0];
    data_d.num_p  = prod_p[hsv2rgb_pkg::NumWidth-1:0];
    data_d.num_q  = prod_q[hsv2rgb_pkg::NumWidth-1:0];
    data_d.num_t  = prod_t[hsv2rgb_pkg::NumWidth-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

[hw/rtl/hsv2rgb_chan.sv]
// ----------------------------------------------------------------------------
// HSV to RGB channel stage
// Turns each numerator into an 8-bit channel and routes the four channels to
// red, green and blue by sector. This stage is the output register.
// ----------------------------------------------------------------------------
module hsv2rgb_chan (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  valid_i,
  output logic                  ready_o,
  input  hsv2rgb_pkg::nums_t    data_i,
  output logic                  valid_o,
  input  logic                  ready_i,
  output hsv2rgb_pkg::rgb_t     data_o
);

  localparam int unsigned WideWidth = hsv2rgb_pkg::NumWidth + 8;

  logic                                    valid_q;
  hsv2rgb_pkg::rgb_t                       data_d, data_q;
  logic [hsv2rgb_pkg::ChanWidth-1:0]       ch_v, ch_p, ch_q, ch_t;

  // floor(n * 255 / (65536 * 60)), with the division by 60 done by reciprocal.
  function automatic logic [hsv2rgb_pkg::ChanWidth-1:0] to_chan(
    logic [hsv2rgb_pkg::NumWidth-1:0] num
  );
    logic [WideWidth-1:0]                    wide;
    logic [hsv2rgb_pkg::ScaleWidth-1:0]      mid;
    logic [hsv2rgb_pkg::ScaleWidth+14:0]     prod;
    wide = {num, 8'd0} - {8'd0, num};
    mid  = wide[16 +: hsv2rgb_pkg::ScaleWidth];
    prod = mid * hsv2rgb_pkg::Chan60Mul;
    return prod[hsv2rgb_pkg::Chan60Shift +: hsv2rgb_pkg::ChanWidth];
  endfunction

  assign ready_o = !valid_q || ready_i;

  always_comb begin
    ch_v = to_chan(data_i.num_v);
    ch_p = to_chan(data_i.num_p);
    ch_q = to_chan(data_i.num_q);
    ch_t = to_chan(data_i.num_t);
    unique case (data_i.sector)
      hsv2rgb_pkg::SecYelGrn: begin
        data_d.red = ch_q; data_d.green = ch_v; data_d.blue = ch_p;
      end
      hsv2rgb_pkg::SecGrnCyn: begin
        data_d.red = ch_p; data_d.green = ch_v; data_d.blue = ch_t;
      end
      hsv2rgb_pkg::SecCynBlu: begin
        data_d.red = ch_p; data_d.green = ch_q; data_d.blue = ch_v;
      end
      hsv2rgb_pkg::SecBluMag: begin
        data_d.red = ch_t; data_d.green = ch_p; data_d.blue = ch_v;
      end
      hsv2rgb_pkg::SecMagRed: begin
        data_d.red = ch_v; data_d.green = ch_p; data_d.blue = ch_q;
      end
      default: begin
        data_d.red = ch_v; data_d.green = ch_t; data_d.blue = ch_p;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

[dv/tb.sv]
// ----------------------------------------------------------------------------
// HSV to RGB converter testbench
// Streams HSV pixel words into the converter and checks every RGB word it
// returns against an in-bench prediction, in order. A directed set covers the
// hue wrap, sector edges and clamping. Random pixels then run under several
// patterns of source gaps and sink back-pressure, including one long sink hold.
// ----------------------------------------------------------------------------
module tb;

  localparam int DegTurn    = 360;
  localparam int DegSector  = 60;
  localparam int UnitOne    = 256;
  localparam int ChanFull   = 255;
  localparam int TermFull   = UnitOne * DegSector;
  localparam longint unsigned ChanDenom = 64'd256 * 64'd256 * 64'd60;

  localparam int QuietLimit = 1000;
  localparam int LongHold   = 150;
  localparam int TailCycles = 20;

  logic                                 clk_i = 1'b0;
  logic                                 rst_ni = 1'b0;
  logic                                 s_axis_tvalid_i = 1'b0;
  logic                                 s_axis_tready_o;
  logic [hsv2rgb_pkg::InDataWidth-1:0]  s_axis_tdata_i = '0;
  logic                                 m_axis_tvalid_o;
  logic                                 m_axis_tready_i = 1'b0;
  logic [hsv2rgb_pkg::OutDataWidth-1:0] m_axis_tdata_o;

  hsv2rgb_pkg::pixel_t pixel_q[$];
  hsv2rgb_pkg::rgb_t   rgb_due_q[$];

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_ticket    = 0;
  int hold_seen      = 0;
  int hold_cnt       = 0;
  int quiet_cycles   = 0;
  int errors         = 0;

  hsv2rgb_pkg::pixel_t drv_px;
  hsv2rgb_pkg::pixel_t mon_px;
  hsv2rgb_pkg::rgb_t   got_rgb;
  hsv2rgb_pkg::rgb_t   want_rgb;

  hsv_to_rgb_converter_unit uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  function automatic int unit_level(logic signed [hsv2rgb_pkg::FixWidth-1:0] x);
    if (x < 0) begin
      return 0;
    end
    if (x > UnitOne) begin
      return UnitOne;
    end
    return x;
  endfunction

  function automatic logic [hsv2rgb_pkg::ChanWidth-1:0] scale_channel(
    longint unsigned num
  );
    return hsv2rgb_pkg::ChanWidth'((num * ChanFull) / ChanDenom);
  endfunction

  function automatic hsv2rgb_pkg::rgb_t hsv_to_rgb(hsv2rgb_pkg::pixel_t px);
    int hue;
    int sat;
    int val;
    int rem;
    logic [hsv2rgb_pkg::SecWidth-1:0]  sec;
    logic [hsv2rgb_pkg::ChanWidth-1:0] ch_v;
    logic [hsv2rgb_pkg::ChanWidth-1:0] ch_p;
    logic [hsv2rgb_pkg::ChanWidth-1:0] ch_q;
    logic [hsv2rgb_pkg::ChanWidth-1:0] ch_t;
    hsv2rgb_pkg::rgb_t rgb;
    hue = $signed(px.hue_deg);
    hue = hue % DegTurn;
    if (hue < 0) begin
      hue = hue + DegTurn;
    end
    sat = unit_level(px.saturation);
    val = unit_level(px.brightness);
    sec = hsv2rgb_pkg::SecWidth'(hue / DegSector);
    rem = hue % DegSector;
    ch_v = scale_channel(longint'(val) * TermFull);
    ch_p = scale_channel(longint'(val) * (UnitOne - sat) * DegSector);
    ch_q = scale_channel(longint'(val) * (TermFull - sat * rem));
    ch_t = scale_channel(longint'(val) * (TermFull - sat * (DegSector - rem)));
    case (sec)
      hsv2rgb_pkg::SecYelGrn: begin
        rgb.red = ch_q; rgb.green = ch_v; rgb.blue = ch_p;
      end
      hsv2rgb_pkg::SecGrnCyn: begin
        rgb.red = ch_p; rgb.green = ch_v; rgb.blue = ch_t;
      end
      hsv2rgb_pkg::SecCynBlu: begin
        rgb.red = ch_p; rgb.green = ch_q; rgb.blue = ch_v;
      end
      hsv2rgb_pkg::SecBluMag: begin
        rgb.red = ch_t; rgb.green = ch_p; rgb.blue = ch_v;
      end
      hsv2rgb_pkg::SecMagRed: begin
        rgb.red = ch_v; rgb.green = ch_p; rgb.blue = ch_q;
      end
      default: begin
        rgb.red = ch_v; rgb.green = ch_t; rgb.blue = ch_p;
      end
    endcase
    return rgb;
  endfunction

  function automatic logic signed [hsv2rgb_pkg::FixWidth-1:0] random_unit();
    int pick;
    pick = $urandom_range(9);
    if (pick < 5) begin
      return hsv2rgb_pkg::FixWidth'($urandom_range(UnitOne));
    end
    if (pick < 7) begin
      return hsv2rgb_pkg::FixWidth'(int'($urandom_range(2)) - 1
                                    + UnitOne * int'($urandom_range(1)));
    end
    return hsv2rgb_pkg::FixWidth'($urandom);
  endfunction

  function automatic hsv2rgb_pkg::pixel_t random_pixel();
    int pick;
    hsv2rgb_pkg::pixel_t px;
    pick = $urandom_range(9);
    if (pick < 4) begin
      px.hue_deg = hsv2rgb_pkg::HueWidth'($urandom);
    end else if (pick < 7) begin
      px.hue_deg = hsv2rgb_pkg::HueWidth'($urandom_range(DegTurn - 1));
    end else begin
      px.hue_deg = hsv2rgb_pkg::HueWidth'(DegSector * int'($urandom_range(18)) - DegTurn
                                          + int'($urandom_range(2)) - 1);
    end
    px.saturation = random_unit();
    px.brightness = random_unit();
    return px;
  endfunction

  task automatic push_pixel(int hue, int sat, int val);
    hsv2rgb_pkg::pixel_t px;
    px.hue_deg    = hsv2rgb_pkg::HueWidth'(hue);
    px.saturation = hsv2rgb_pkg::FixWidth'(sat);
    px.brightness = hsv2rgb_pkg::FixWidth'(val);
    pixel_q.push_back(px);
  endtask

  task automatic push_random(int count);
    repeat (count) pixel_q.push_back(random_pixel());
  endtask

  task automatic drain();
    while (pixel_q.size() != 0 || s_axis_tvalid_i || rgb_due_q.size() != 0) begin
      @(negedge clk_i);
    end
  endtask

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (rst_ni && (!s_axis_tvalid_i || s_axis_tready_o)) begin
      if (pixel_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        drv_px = pixel_q.pop_front();
        s_axis_tvalid_i <= 1'b1;
        s_axis_tdata_i  <= {4'b0, drv_px.brightness, drv_px.saturation, drv_px.hue_deg};
      end else begin
        s_axis_tvalid_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    if (hold_cnt > 0) begin
      hold_cnt        <= hold_cnt - 1;
      m_axis_tready_i <= 1'b0;
    end else if (hold_seen != hold_ticket) begin
      hold_seen       <= hold_ticket;
      hold_cnt        <= LongHold;
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        mon_px.hue_deg    = s_axis_tdata_i[15:0];
        mon_px.saturation = s_axis_tdata_i[25:16];
        mon_px.brightness = s_axis_tdata_i[35:26];
        rgb_due_q.push_back(hsv_to_rgb(mon_px));
      end
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        got_rgb = m_axis_tdata_o;
        if (rgb_due_q.size() == 0) begin
          errors++;
          $display("%0t: expected no word, got r=%0d g=%0d b=%0d", $time,
                   got_rgb.red, got_rgb.green, got_rgb.blue);
        end else begin
          want_rgb = rgb_due_q.pop_front();
          if (got_rgb.red !== want_rgb.red || got_rgb.green !== want_rgb.green ||
              got_rgb.blue !== want_rgb.blue) begin
            errors++;
            $display("%0t: expected r=%0d g=%0d b=%0d, got r=%0d g=%0d b=%0d", $time,
                     want_rgb.red, want_rgb.green, want_rgb.blue,
                     got_rgb.red, got_rgb.green, got_rgb.blue);
          end
        end
      end
      if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    wait (quiet_cycles >= QuietLimit);
    $display("** hsv_to_rgb_converter_unit: FAILED **");
    $finish;
  end

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Sector edges, hue wrap and clamping of saturation and value.
    push_pixel(0, 256, 256);
    push_pixel(59, 256, 256);
    push_pixel(60, 256, 256);
    push_pixel(119, 200, 256);
    push_pixel(120, 256, 200);
    push_pixel(179, 128, 256);
    push_pixel(180, 256, 256);
    push_pixel(239, 100, 150);
    push_pixel(240, 256, 256);
    push_pixel(299, 255, 255);
    push_pixel(300, 256, 256);
    push_pixel(359, 256, 256);
    push_pixel(360, 256, 256);
    push_pixel(-1, 256, 256);
    push_pixel(-360, 180, 220);
    push_pixel(-32768, 511, 511);
    push_pixel(32767, -512, -512);
    push_pixel(30, -1, 257);
    push_pixel(90, 257, -1);
    push_pixel(200, 256, 0);
    push_pixel(45, 0, 256);
    push_pixel(210, 0, 0);
    push_pixel(330, 1, 1);
    push_pixel(150, 511, 256);
    drain();

    // The sink holds off while the source keeps offering, filling the pipe.
    hold_ticket++;
    push_random(300);
    drain();

    send_idle_pct  = 68;
    recv_stall_pct = 0;
    push_random(350);
    drain();

    send_idle_pct  = 0;
    recv_stall_pct = 68;
    push_random(350);
    drain();

    send_idle_pct  = 7;
    recv_stall_pct = 7;
    push_random(350);
    drain();

    send_idle_pct  = 0;
    recv_stall_pct = 0;
    push_random(300);
    drain();

    repeat (TailCycles) @(negedge clk_i);
    if (errors == 0 && rgb_due_q.size() == 0) begin
      $display("** hsv_to_rgb_converter_unit: PASSED **");
    end else begin
      $display("** hsv_to_rgb_converter_unit: FAILED **");
    end
    $finish;
  end

endmodule

[hsv_to_rgb_converter_unit.f]
hw/rtl/hsv2rgb_pkg.sv
hw/rtl/hsv2rgb_wrap.sv
hw/rtl/hsv2rgb_terms.sv
hw/rtl/hsv2rgb_mult.sv
hw/rtl/hsv2rgb_chan.sv
hw/rtl/hsv_to_rgb_converter_unit.sv
dv/tb.sv
